>>> hw/rtl/delta_list_timer_scheduler_defines.svh
// assertion helpers for the timer scheduler
`ifndef DELTA_LIST_TIMER_SCHEDULER_DEFINES_SVH
`define DELTA_LIST_TIMER_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DLTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dlts_pkg.sv
package dlts_pkg;

  localparam int SLOTS = 8;
  localparam int TAG_W = 8;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int SUM_W = 32 + $clog2(SLOTS) + 1;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_TAIL_LOST = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [31:0]      delta;
    logic [31:0]      period;
    logic             ready;
    logic [31:0]      id;
  } slot_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_TICK,
    CMD_SHIFT_UP,
    CMD_SHIFT_DN
  } cmd_kind_t;

  // broadcast to every cell
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      alt_delta;
    slot_t            fill;
  } cell_cmd_t;

endpackage

>>> hw/rtl/dlts_cell.sv
module dlts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dlts_pkg::IDX_W-1:0] cell_idx,
  input  dlts_pkg::cell_cmd_t       cmd,
  input  dlts_pkg::slot_t           lower,
  input  dlts_pkg::slot_t           upper,
  output dlts_pkg::slot_t           slot
);

  dlts_pkg::slot_t slot_r;
  dlts_pkg::slot_t slot_nxt;
  logic [dlts_pkg::IDX_W:0] me_w;
  logic [dlts_pkg::IDX_W:0] idx_w;

  assign me_w  = {1'b0, cell_idx};
  assign idx_w = {1'b0, cmd.idx};

  // next slot contents
  always_comb begin
    slot_nxt = slot_r;
    case (cmd.kind)
      dlts_pkg::CMD_TICK: begin
        if (me_w == '0 && slot_r.valid && !slot_r.ready) begin
          if (slot_r.delta != 32'd0) begin
            slot_nxt.delta = slot_r.delta - 32'd1;
          end
          slot_nxt.ready = (slot_r.delta <= 32'd1);
        end
      end
      dlts_pkg::CMD_SHIFT_UP: begin
        if (me_w == idx_w) begin
          slot_nxt = cmd.fill;
        end else if (me_w == idx_w + 1'b1) begin
          slot_nxt       = lower;
          slot_nxt.delta = cmd.alt_delta;
        end else if (me_w > idx_w) begin
          slot_nxt = lower;
        end
      end
      dlts_pkg::CMD_SHIFT_DN: begin
        if (me_w == idx_w) begin
          slot_nxt       = upper;
          slot_nxt.delta = cmd.alt_delta;
        end else if (me_w > idx_w) begin
          slot_nxt = upper;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

>>> hw/rtl/delta_list_timer_scheduler.sv
// tick, delete of id 0, and dispatch with nothing ready answer in the next cycle
// delete goes through S_DEL_FIND and S_SHIFT_DN (an absent id answers from S_DEL_FIND);
// one-shot dispatch goes through S_SHIFT_DN; add walks the cell chain in S_ADD_WALK;
// periodic dispatch runs S_SHIFT_DN, then the add walk; one command at a time (busy)
// each result word shows for one cycle on out_valid; the receiver cannot stall
// reset (synchronous, rst_n low) empties every slot and restarts ids at 1
`include "delta_list_timer_scheduler_defines.svh"

module delta_list_timer_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_task_tag,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [31:0] in_target_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_run_valid,
  output logic [7:0]  out_run_tag,
  output logic [31:0] out_assigned_id
);

  localparam int SLOTS = dlts_pkg::SLOTS;
  localparam int IDX_W = dlts_pkg::IDX_W;
  localparam int SUM_W = dlts_pkg::SUM_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_WALK,
    S_DEL_FIND,
    S_SHIFT_DN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [dlts_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [31:0]              delay_r, delay_nxt;
  logic [31:0]              period_r, period_nxt;
  logic [31:0]              target_r, target_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic                     disp_r, disp_nxt;
  logic [31:0]              idc_r, idc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               status_r, status_nxt;
  logic                     run_valid_r, run_valid_nxt;
  logic [7:0]               run_tag_r, run_tag_nxt;
  logic [31:0]              assigned_r, assigned_nxt;

  dlts_pkg::slot_t     slots [SLOTS];
  dlts_pkg::cell_cmd_t cmd;

  // cell chain
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dlts_pkg::slot_t lo, hi;
    if (g == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = slots[g-1];
    end
    if (g == SLOTS - 1) begin : g_hil
      assign hi = '0;
    end else begin : g_hi
      assign hi = slots[g+1];
    end
    dlts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(IDX_W'(g)),
      .cmd     (cmd),
      .lower   (lo),
      .upper   (hi),
      .slot    (slots[g])
    );
  end

  // walk and fold arithmetic
  dlts_pkg::slot_t  cur, nxt_slot;
  logic [SUM_W-1:0] nsum;
  logic             past_delay;
  logic [32:0]      fold;
  logic [31:0]      fold_sat;
  logic [31:0]      new_id;
  logic [SLOTS-1:0] match;
  logic             found;
  logic [IDX_W-1:0] found_idx;

  assign cur        = slots[idx_r];
  assign nxt_slot   = slots[(idx_r == LAST) ? idx_r : idx_r + 1'b1];
  assign nsum       = sum_r + SUM_W'(cur.delta);
  assign past_delay = nsum > SUM_W'(delay_r);
  assign fold       = {1'b0, nxt_slot.delta} + {1'b0, cur.delta};
  assign fold_sat   = fold[32] ? 32'hFFFF_FFFF : fold[31:0];
  assign new_id     = (idc_r == 32'hFFFF_FFFF) ? 32'd1 : idc_r + 32'd1;

  // id match per cell, first hit wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = slots[i].valid && (slots[i].id == target_r);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    delay_nxt     = delay_r;
    period_nxt    = period_r;
    target_nxt    = target_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    disp_nxt      = disp_r;
    idc_nxt       = idc_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    run_valid_nxt = run_valid_r;
    run_tag_nxt   = run_tag_r;
    assigned_nxt  = assigned_r;
    cmd             = '0;
    cmd.kind        = dlts_pkg::CMD_HOLD;
    cmd.idx         = idx_r;
    cmd.fill.valid  = 1'b1;
    cmd.fill.tag    = tag_r;
    cmd.fill.delta  = delay_r - sum_r[31:0];
    cmd.fill.period = period_r;
    cmd.fill.ready  = (delay_r == sum_r[31:0]);
    cmd.fill.id     = new_id;
    cmd.alt_delta   = 32'(nsum - SUM_W'(delay_r));
    case (state_r)
      S_IDLE: begin
        if (start) begin
          tag_nxt       = in_task_tag;
          delay_nxt     = in_first_delay;
          period_nxt    = in_repeat_period;
          target_nxt    = in_target_id;
          idx_nxt       = '0;
          sum_nxt       = '0;
          disp_nxt      = 1'b0;
          status_nxt    = dlts_pkg::ST_DONE;
          run_valid_nxt = 1'b0;
          run_tag_nxt   = '0;
          assigned_nxt  = '0;
          case (in_operation)
            dlts_pkg::OP_TICK: begin
              cmd.kind      = dlts_pkg::CMD_TICK;
              out_valid_nxt = 1'b1;
            end
            dlts_pkg::OP_ADD: begin
              state_nxt = S_ADD_WALK;
            end
            dlts_pkg::OP_DELETE: begin
              if (in_target_id == 32'd0) begin
                status_nxt    = dlts_pkg::ST_NOT_FOUND;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_DEL_FIND;
              end
            end
            default: begin
              if (slots[0].valid && slots[0].ready) begin
                tag_nxt     = slots[0].tag;
                delay_nxt   = slots[0].period;
                period_nxt  = slots[0].period;
                run_tag_nxt = 8'(slots[0].tag);
                disp_nxt    = 1'b1;
                state_nxt   = S_SHIFT_DN;
              end else begin
                status_nxt    = dlts_pkg::ST_NOT_READY;
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_ADD_WALK: begin
        if (!cur.valid || past_delay) begin
          cmd.kind      = dlts_pkg::CMD_SHIFT_UP;
          idc_nxt       = new_id;
          assigned_nxt  = new_id;
          status_nxt    = (cur.valid && slots[SLOTS-1].valid) ?
                          dlts_pkg::ST_TAIL_LOST : dlts_pkg::ST_DONE;
          run_valid_nxt = disp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (idx_r == LAST) begin
          status_nxt    = dlts_pkg::ST_DROPPED;
          assigned_nxt  = '0;
          run_valid_nxt = disp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          sum_nxt = nsum;
        end
      end
      S_DEL_FIND: begin
        if (found) begin
          idx_nxt   = found_idx;
          state_nxt = S_SHIFT_DN;
        end else begin
          status_nxt    = dlts_pkg::ST_NOT_FOUND;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        // remove slot idx, folding its delta into the successor
        cmd.kind      = dlts_pkg::CMD_SHIFT_DN;
        cmd.alt_delta = fold_sat;
        if (disp_r && period_r != 32'd0) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_ADD_WALK;
        end else begin
          status_nxt    = dlts_pkg::ST_DONE;
          run_valid_nxt = disp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idc_r       <= '0;
      out_valid_r <= 1'b0;
      disp_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
      disp_r      <= disp_nxt;
    end
    tag_r       <= tag_nxt;
    delay_r     <= delay_nxt;
    period_r    <= period_nxt;
    target_r    <= target_nxt;
    idx_r       <= idx_nxt;
    sum_r       <= sum_nxt;
    status_r    <= status_nxt;
    run_valid_r <= run_valid_nxt;
    run_tag_r   <= run_tag_nxt;
    assigned_r  <= assigned_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_run_valid   = out_valid_r & run_valid_r;
  assign out_run_tag     = out_valid_r ? run_tag_r : 8'd0;
  assign out_assigned_id = out_valid_r ? assigned_r : 32'd0;

  // checks
  `DLTS_ASSERT_NOW(a_word_when_idle, out_valid, !busy, "result word while busy")
  `DLTS_ASSERT_NOW(a_run_status, out_run_valid, out_valid && (out_status == dlts_pkg::ST_DONE || out_status == dlts_pkg::ST_TAIL_LOST || out_status == dlts_pkg::ST_DROPPED), "bad status on dispatch")
  `DLTS_ASSERT_NOW(a_drop_no_id, out_valid && out_status == dlts_pkg::ST_DROPPED, out_assigned_id == 32'd0, "dropped task got an id")
  `DLTS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "accepted command lost")

endmodule

>>> dv/delta_list_timer_scheduler_checker.sv
`timescale 1ns / 1ps

module delta_list_timer_scheduler_checker
  import dlts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_task_tag,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [31:0] in_target_id,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic        out_run_valid,
  input  logic [7:0]  out_run_tag,
  input  logic [31:0] out_assigned_id,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic        run_valid;
    logic [7:0]  run_tag;
    logic [31:0] assigned_id;
  } sched_word_t;

  // shadow timer list
  slot_t       queue_slot[SLOTS];
  logic [31:0] last_id;
  sched_word_t expected_words[$];

  function automatic logic [31:0] alloc_id();
    last_id = last_id + 32'd1;
    if (last_id == 32'd0) last_id = 32'd1;
    return last_id;
  endfunction

  function automatic void put_slot(int i, logic [7:0] tag, logic [31:0] delta,
                                   logic [31:0] period, ref logic [31:0] id);
    queue_slot[i].valid  = 1'b1;
    queue_slot[i].tag    = tag;
    queue_slot[i].delta  = delta;
    queue_slot[i].period = period;
    queue_slot[i].ready  = (delta == 32'd0);
    id = alloc_id();
    queue_slot[i].id = id;
  endfunction

  // sorted insert by running sum, returns status
  function automatic logic [2:0] insert_timer(logic [7:0] tag, logic [31:0] delay,
                                              logic [31:0] period,
                                              ref logic [31:0] id);
    logic [63:0] sum;
    logic [63:0] prior;
    logic [2:0]  st;
    sum = 0;
    id = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!queue_slot[i].valid) begin
        put_slot(i, tag, 32'(64'(delay) - sum), period, id);
        return ST_DONE;
      end
      sum += queue_slot[i].delta;
      if (sum > 64'(delay)) begin
        prior = sum - queue_slot[i].delta;
        st = queue_slot[SLOTS-1].valid ? ST_TAIL_LOST : ST_DONE;
        queue_slot[i].delta = 32'(sum - 64'(delay));
        for (int k = SLOTS - 1; k > i; k--) queue_slot[k] = queue_slot[k-1];
        put_slot(i, tag, delay - 32'(prior), period, id);
        return st;
      end
    end
    return ST_DROPPED;
  endfunction

  function automatic void remove_slot(int idx);
    logic [32:0] s;
    if (idx < SLOTS - 1 && queue_slot[idx+1].valid) begin
      s = 33'(queue_slot[idx+1].delta) + 33'(queue_slot[idx].delta);
      queue_slot[idx+1].delta = s[32] ? 32'hFFFF_FFFF : s[31:0];
    end
    for (int j = idx; j < SLOTS - 1; j++) queue_slot[j] = queue_slot[j+1];
    queue_slot[SLOTS-1] = '0;
  endfunction

  function automatic sched_word_t schedule_step(logic [1:0] op, logic [7:0] tag,
                                                logic [31:0] delay,
                                                logic [31:0] period,
                                                logic [31:0] target);
    sched_word_t w;
    logic [31:0] id;
    logic [7:0]  t;
    logic [31:0] p;
    w = '0;
    id = 0;
    case (op)
      OP_TICK: begin
        if (queue_slot[0].valid && !queue_slot[0].ready) begin
          if (queue_slot[0].delta > 0) queue_slot[0].delta -= 32'd1;
          if (queue_slot[0].delta == 0) queue_slot[0].ready = 1'b1;
        end
      end
      OP_ADD: begin
        w.status = insert_timer(tag, delay, period, id);
        w.assigned_id = id;
      end
      OP_DELETE: begin
        w.status = ST_NOT_FOUND;
        if (target != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (queue_slot[i].valid && queue_slot[i].id == target) begin
              remove_slot(i);
              w.status = ST_DONE;
              break;
            end
          end
        end
      end
      default: begin
        if (queue_slot[0].valid && queue_slot[0].ready) begin
          t = queue_slot[0].tag;
          p = queue_slot[0].period;
          w.run_valid = 1'b1;
          w.run_tag = t;
          remove_slot(0);
          if (p != 0) begin
            w.status = insert_timer(t, p, p, id);
            w.assigned_id = id;
          end
        end else begin
          w.status = ST_NOT_READY;
        end
      end
    endcase
    return w;
  endfunction

  assign pending_count = expected_words.size();

  // predict on accepted words, compare result words
  always @(posedge clk) begin
    sched_word_t exp_w;
    sched_word_t got_w;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) queue_slot[i] = '0;
      last_id = 0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        got_w = '{out_status, out_run_valid, out_run_tag, out_assigned_id};
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", got_w);
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: status %0d/%0d run %0d/%0d tag %h/%h id %h/%h",
                       exp_w.status, got_w.status, exp_w.run_valid, got_w.run_valid,
                       exp_w.run_tag, got_w.run_tag, exp_w.assigned_id,
                       got_w.assigned_id);
          end
        end
      end
      if (start && !busy)
        expected_words.push_back(schedule_step(in_operation, in_task_tag,
                                               in_first_delay, in_repeat_period,
                                               in_target_id));
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dlts_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = OP_TICK;
  logic [7:0]  in_task_tag = '0;
  logic [31:0] in_first_delay = '0;
  logic [31:0] in_repeat_period = '0;
  logic [31:0] in_target_id = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_run_valid;
  logic [7:0]  out_run_tag;
  logic [31:0] out_assigned_id;
  int          fail_count;
  int          pending_count;
  logic [31:0] id_guess;

  always #4 clk = ~clk;

  delta_list_timer_scheduler u_dut (.*);

  delta_list_timer_scheduler_checker u_checker (.*);

  // send one command word, then hold off a random gap
  task automatic send_word(logic [1:0] op, logic [7:0] tag, logic [31:0] delay,
                           logic [31:0] period, logic [31:0] target);
    int gap;
    in_operation     <= op;
    in_task_tag      <= tag;
    in_first_delay   <= delay;
    in_repeat_period <= period;
    in_target_id     <= target;
    start            <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_ADD) id_guess = id_guess + 1;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom();
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int op_pick;
    int waited;
    id_guess = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list corners
    send_word(OP_TICK, 8'h00, 0, 0, 0);
    send_word(OP_DISPATCH, 8'h00, 0, 0, 0);
    send_word(OP_DELETE, 8'h00, 0, 0, 32'd0);
    send_word(OP_DELETE, 8'h00, 0, 0, 32'hFFFF_FFFF);
    // fill past capacity, huge deltas for saturating fold
    send_word(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(OP_ADD, 8'h01, 32'hFFFF_FFFF, 32'd0, 0);
    send_word(OP_ADD, 8'hA5, 32'd0, 32'd3, 0);
    send_word(OP_ADD, 8'h5A, 32'd2, 32'd1, 0);
    send_word(OP_ADD, 8'h11, 32'd5, 32'd0, 0);
    send_word(OP_ADD, 8'h22, 32'h8000_0000, 32'h8000_0000, 0);
    send_word(OP_ADD, 8'h33, 32'd1, 32'd2, 0);
    send_word(OP_ADD, 8'h44, 32'd7, 32'd0, 0);
    send_word(OP_ADD, 8'h55, 32'd3, 32'd0, 0);
    send_word(OP_ADD, 8'h66, 32'hFFFF_FFFF, 32'd0, 0);
    send_word(OP_DISPATCH, 8'h00, 0, 0, 0);
    send_word(OP_DISPATCH, 8'h00, 0, 0, 0);
    send_word(OP_DELETE, 8'h00, 0, 0, 32'd6);
    send_word(OP_DELETE, 8'h00, 0, 0, 32'd6);
    send_word(OP_TICK, 8'h00, 0, 0, 0);
    send_word(OP_TICK, 8'h00, 0, 0, 0);
    send_word(OP_DISPATCH, 8'h00, 0, 0, 0);
    send_word(OP_DELETE, 8'h00, 0, 0, 32'd1);

    // random: ticks and dispatches make half of the commands so tasks come due
    for (int n = 0; n < 1350; n++) begin
      op_pick = $urandom_range(0, 9);
      if (op_pick < 3)
        send_word(OP_TICK, 8'($urandom()), $urandom(), $urandom(), $urandom());
      else if (op_pick < 6)
        send_word(OP_ADD, 8'($urandom()), rand_delay(),
                  ($urandom_range(0, 2) == 0) ? 32'd0 : rand_delay(), $urandom());
      else if (op_pick < 8)
        send_word(OP_DELETE, 8'($urandom()), $urandom(), $urandom(),
                  ($urandom_range(0, 4) == 0) ? $urandom() :
                  id_guess - $urandom_range(0, 10));
      else
        send_word(OP_DISPATCH, 8'($urandom()), $urandom(), $urandom(), $urandom());
      if ($urandom_range(0, 19) == 0) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b0;

    // drain
    waited = 0;
    while (pending_count != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
